@@ rtl/lcdw_pkg.sv @@
`default_nettype none
package lcdw_pkg;

    // request kinds, as carried on the input tuser
    typedef enum logic [1:0] {
        OP_INIT = 2'd0,
        OP_CHAR = 2'd1,
        OP_NUM  = 2'd2,
        OP_NONE = 2'd3
    } t_op;

    // jump conditions of a control word
    typedef enum logic [3:0] {
        C_NEXT   = 4'd0,
        C_NOREQ  = 4'd1,
        C_OPINIT = 4'd2,
        C_OPBAD  = 4'd3,
        C_OPCHAR = 4'd4,
        C_NOTNEG = 4'd5,
        C_BUSY   = 4'd6,
        C_QNZ    = 4'd7,
        C_MORE   = 4'd8
    } t_cond;

    typedef enum logic [1:0] {
        L_NO    = 2'd0,
        L_YES   = 2'd1,
        L_STACK = 2'd2
    } t_last;

    typedef enum logic [1:0] {
        B_CONST  = 2'd0,
        B_CURSOR = 2'd1,
        B_CHAR   = 2'd2,
        B_DIGIT  = 2'd3
    } t_bsel;

    typedef enum logic [1:0] {
        D_NONE = 2'd0,
        D_REQ  = 2'd1,
        D_QUOT = 2'd2
    } t_div;

    typedef struct packed {
        t_cond      cond;
        logic [3:0] target;
        logic       emit;
        logic       is_data;
        t_last      last;
        t_bsel      bsel;
        logic [7:0] konst;
        t_div       div;
        logic       push;
        logic       ret;
    } t_uword;

    // request fields that do not scale with the value width
    typedef struct packed {
        t_op        op;
        logic       neg;
        logic [7:0] cursor;
        logic [7:0] ch;
        logic [5:0] base;
    } t_req;

    typedef struct packed {
        logic       busy;
        logic       qnz;
        logic [5:0] rem;
    } t_div_st;

    localparam logic [3:0] P_IDLE    = 4'd0;
    localparam logic [3:0] P_OPINIT  = 4'd1;
    localparam logic [3:0] P_OPBAD   = 4'd2;
    localparam logic [3:0] P_CURSOR  = 4'd3;
    localparam logic [3:0] P_DIVGO   = 4'd4;
    localparam logic [3:0] P_MINUS   = 4'd5;
    localparam logic [3:0] P_DIVWAIT = 4'd6;
    localparam logic [3:0] P_PUSH    = 4'd7;
    localparam logic [3:0] P_POP     = 4'd8;
    localparam logic [3:0] P_CHAR    = 4'd10;
    localparam logic [3:0] P_INIT0   = 4'd11;
    localparam logic [3:0] P_INIT1   = 4'd12;
    localparam logic [3:0] P_INIT2   = 4'd13;
    localparam logic [3:0] P_INIT3   = 4'd14;

    localparam logic [7:0] LCD_FUNC_SET  = 8'h38;
    localparam logic [7:0] LCD_DISP_ON   = 8'h0C;
    localparam logic [7:0] LCD_ENTRY     = 8'h06;
    localparam logic [7:0] LCD_CLEAR     = 8'h01;
    localparam logic [7:0] LCD_SET_DDRAM = 8'h80;
    localparam logic [7:0] LCD_LINE2     = 8'h40;
    localparam logic [7:0] ASCII_MINUS   = 8'h2D;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_A       = 8'h41;
    localparam logic [5:0] BASE_MIN      = 6'd2;
    localparam logic [5:0] BASE_MAX      = 6'd36;
    localparam logic [5:0] DEC_DIGITS    = 6'd10;

    localparam t_uword UW_NOP = '{
        cond: C_NEXT, target: P_IDLE, emit: 1'b0, is_data: 1'b0, last: L_NO,
        bsel: B_CONST, konst: 8'h00, div: D_NONE, push: 1'b0, ret: 1'b1
    };

    function automatic logic [7:0] to_ascii(input logic [5:0] d);
        logic [7:0] d8;
        d8 = {2'b00, d};
        return (d < DEC_DIGITS) ? (ASCII_ZERO + d8) : (ASCII_A + d8 - {2'b00, DEC_DIGITS});
    endfunction

    // control store
    function automatic t_uword ucode(input logic [3:0] pc);
        t_uword w;
        w = UW_NOP;
        w.ret = 1'b0;
        unique case (pc)
            P_IDLE: begin
                w.cond = C_NOREQ; w.target = P_IDLE;
            end
            P_OPINIT: begin
                w.cond = C_OPINIT; w.target = P_INIT0;
            end
            P_OPBAD: begin
                w.cond = C_OPBAD; w.target = P_IDLE;
            end
            P_CURSOR: begin
                w.emit = 1'b1; w.bsel = B_CURSOR;
                w.cond = C_OPCHAR; w.target = P_CHAR;
            end
            P_DIVGO: begin
                w.div = D_REQ; w.cond = C_NOTNEG; w.target = P_DIVWAIT;
            end
            P_MINUS: begin
                w.emit = 1'b1; w.is_data = 1'b1; w.konst = ASCII_MINUS;
            end
            P_DIVWAIT: begin
                w.cond = C_BUSY; w.target = P_DIVWAIT;
            end
            P_PUSH: begin
                w.push = 1'b1; w.div = D_QUOT;
                w.cond = C_QNZ; w.target = P_DIVWAIT;
            end
            P_POP: begin
                w.emit = 1'b1; w.is_data = 1'b1; w.bsel = B_DIGIT; w.last = L_STACK;
                w.cond = C_MORE; w.target = P_POP; w.ret = 1'b1;
            end
            P_CHAR: begin
                w.emit = 1'b1; w.is_data = 1'b1; w.bsel = B_CHAR; w.last = L_YES;
                w.ret = 1'b1;
            end
            P_INIT0: begin
                w.emit = 1'b1; w.konst = LCD_FUNC_SET;
            end
            P_INIT1: begin
                w.emit = 1'b1; w.konst = LCD_DISP_ON;
            end
            P_INIT2: begin
                w.emit = 1'b1; w.konst = LCD_ENTRY;
            end
            P_INIT3: begin
                w.emit = 1'b1; w.konst = LCD_CLEAR; w.last = L_YES; w.ret = 1'b1;
            end
            default: begin
                w = UW_NOP;
            end
        endcase
        return w;
    endfunction

endpackage
`default_nettype wire

@@ rtl/lcdw_divider.sv @@
`default_nettype none
// restoring divider, one quotient bit per cycle
module lcdw_divider #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire                         i_clk,
    input  wire                         i_rst_n,
    input  wire                         i_start,
    input  wire        [VALUE_WIDTH-1:0] i_dividend,
    input  wire        [5:0]            i_divisor,
    output logic       [VALUE_WIDTH-1:0] o_quot,
    output lcdw_pkg::t_div_st           o_st
);
    import lcdw_pkg::*;

    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic                   r_busy;
    logic [CW-1:0]          r_cnt;
    logic [VALUE_WIDTH-1:0] r_q;
    logic [5:0]             r_rem;
    logic [6:0]             sh;
    logic [6:0]             diff;
    logic                   ge;

    assign sh   = {r_rem, r_q[VALUE_WIDTH-1]};
    assign ge   = sh >= {1'b0, i_divisor};
    assign diff = sh - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CW'(VALUE_WIDTH);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CW'(1);
            if (r_cnt == CW'(1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
        end else if (r_busy) begin
            r_q   <= {r_q[VALUE_WIDTH-2:0], ge};
            r_rem <= ge ? diff[5:0] : sh[5:0];
        end
    end

    assign o_quot    = r_q;
    assign o_st.busy = r_busy;
    assign o_st.qnz  = |r_q;
    assign o_st.rem  = r_rem;

endmodule
`default_nettype wire

@@ rtl/lcdw_sequencer.sv @@
`default_nettype none
// microprogram counter, control store decode, digit stack and output register
module lcdw_sequencer #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_req_valid,
    input  lcdw_pkg::t_req       i_req,
    input  lcdw_pkg::t_div_st    i_dst,
    input  wire                  i_m_tready,
    output logic                 o_ready,
    output lcdw_pkg::t_div       o_div,
    output logic                 o_m_tvalid,
    output logic [7:0]           o_m_tdata,
    output logic                 o_m_tuser,
    output logic                 o_m_tlast
);
    import lcdw_pkg::*;

    localparam int IW = $clog2(VALUE_WIDTH);
    localparam int CW = $clog2(VALUE_WIDTH + 1);

    logic [3:0]    r_pc;
    logic [3:0]    n_pc;
    logic [CW-1:0] r_cnt;
    logic [5:0]    r_stack [VALUE_WIDTH];
    logic          r_ov;
    logic [7:0]    r_byte;
    logic          r_isd;
    logic          r_last;

    t_uword        w;
    logic          stall;
    logic          jump;
    logic          fire;
    logic          pop;
    logic [CW-1:0] cnt_m1;
    logic [7:0]    byte_sel;
    logic          last_sel;

    assign w      = ucode(r_pc);
    assign stall  = w.emit && r_ov && !i_m_tready;
    assign fire   = w.emit && !stall;
    assign pop    = fire && (w.bsel == B_DIGIT);
    assign cnt_m1 = r_cnt - CW'(1);

    // next step
    always_comb begin
        case (w.cond)
            C_NOREQ:  jump = !i_req_valid;
            C_OPINIT: jump = i_req.op == OP_INIT;
            C_OPBAD:  jump = i_req.op == OP_NONE;
            C_OPCHAR: jump = i_req.op == OP_CHAR;
            C_NOTNEG: jump = !i_req.neg;
            C_BUSY:   jump = i_dst.busy;
            C_QNZ:    jump = i_dst.qnz;
            C_MORE:   jump = r_cnt > CW'(1);
            default:  jump = 1'b0;
        endcase
        if (stall) begin
            n_pc = r_pc;
        end else if (jump) begin
            n_pc = w.target;
        end else if (w.ret) begin
            n_pc = P_IDLE;
        end else begin
            n_pc = r_pc + 4'd1;
        end
    end

    // datapath controls
    always_comb begin
        case (w.bsel)
            B_CURSOR: byte_sel = i_req.cursor;
            B_CHAR:   byte_sel = i_req.ch;
            B_DIGIT:  byte_sel = to_ascii(r_stack[cnt_m1[IW-1:0]]);
            default:  byte_sel = w.konst;
        endcase
        case (w.last)
            L_YES:   last_sel = 1'b1;
            L_STACK: last_sel = r_cnt == CW'(1);
            default: last_sel = 1'b0;
        endcase
        o_div   = stall ? D_NONE : w.div;
        o_ready = (r_pc == P_IDLE) && i_rst_n;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc  <= P_IDLE;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_pc <= n_pc;
            if (w.push) begin
                r_cnt <= r_cnt + CW'(1);
            end else if (pop) begin
                r_cnt <= cnt_m1;
            end
            if (fire) begin
                r_ov <= 1'b1;
            end else if (i_m_tready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w.push) begin
            r_stack[r_cnt[IW-1:0]] <= i_dst.rem;
        end
        if (fire) begin
            r_byte <= byte_sel;
            r_isd  <= w.is_data;
            r_last <= last_sel;
        end
    end

    assign o_m_tvalid = r_ov;
    assign o_m_tdata  = r_byte;
    assign o_m_tuser  = r_isd;
    assign o_m_tlast  = r_last;

    a_idle_stack_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_pc == P_IDLE) |-> (r_cnt == '0))
        else $error("digit stack not empty at idle");

    a_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pop |-> (r_cnt != '0))
        else $error("digit pop from empty stack");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w.push |-> (r_cnt < CW'(VALUE_WIDTH)))
        else $error("digit stack overflow");

    a_div_done_on_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w.push |-> !i_dst.busy)
        else $error("digit pushed while divider busy");

endmodule
`default_nettype wire

@@ rtl/char_lcd_text_number_writer.sv @@
// Character LCD write sequencer: one request in, a run of bus writes out.
// Number digits come from repeated division on the bit-serial divider.
// One request at a time; output backpressure stalls the sequencer.
// Synchronous active-low reset returns the sequencer to idle.
`default_nettype none
module char_lcd_text_number_writer #(
    parameter int VALUE_WIDTH = 16
) (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_s_axis_tvalid,
    output logic                         o_s_axis_tready,
    // row[1:0], col[5:0], value[VALUE_WIDTH-1:0], base[5:0], char_code[7:0], zero pad
    input  wire  [((22+VALUE_WIDTH+7)/8)*8-1:0] i_s_axis_tdata,
    // op[1:0]
    input  wire  [1:0]                   i_s_axis_tuser,
    output logic                         o_m_axis_tvalid,
    input  wire                          i_m_axis_tready,
    // bus_byte[7:0]
    output logic [7:0]                   o_m_axis_tdata,
    // is_data
    output logic                         o_m_axis_tuser,
    output logic                         o_m_axis_tlast
);
    import lcdw_pkg::*;

    localparam int V_LO = 8;
    localparam int B_LO = V_LO + VALUE_WIDTH;
    localparam int C_LO = B_LO + 6;

    logic                   accept;
    t_req                   r_req;
    logic [VALUE_WIDTH-1:0] r_mag;
    logic [1:0]             in_row;
    logic [5:0]             in_col;
    logic [VALUE_WIDTH-1:0] in_val;
    logic [5:0]             in_base;
    logic [7:0]             in_char;
    logic [7:0]             addr;
    logic [5:0]             base_c;

    t_div                   div_cmd;
    t_div_st                div_st;
    logic [VALUE_WIDTH-1:0] quot;
    logic [VALUE_WIDTH-1:0] dividend;

    assign accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign in_row  = i_s_axis_tdata[1:0];
    assign in_col  = i_s_axis_tdata[7:2];
    assign in_val  = i_s_axis_tdata[B_LO-1:V_LO];
    assign in_base = i_s_axis_tdata[C_LO-1:B_LO];
    assign in_char = i_s_axis_tdata[C_LO+7:C_LO];

    // DDRAM address: column is one-based, second line starts at 0x40
    assign addr   = ({2'b00, in_col} - 8'd1) + ((in_row != 2'd1) ? LCD_LINE2 : 8'h00);
    assign base_c = (in_base < BASE_MIN) ? BASE_MIN :
                    (in_base > BASE_MAX) ? BASE_MAX : in_base;

    // capture the request; magnitude is unsigned so the most negative value prints
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_req.op     <= t_op'(i_s_axis_tuser);
            r_req.neg    <= in_val[VALUE_WIDTH-1];
            r_req.cursor <= LCD_SET_DDRAM | addr;
            r_req.ch     <= in_char;
            r_req.base   <= base_c;
            r_mag        <= in_val[VALUE_WIDTH-1] ? (~in_val + VALUE_WIDTH'(1)) : in_val;
        end
    end

    // first divide takes the magnitude, later ones the previous quotient
    assign dividend = (div_cmd == D_REQ) ? r_mag : quot;

    lcdw_divider #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_cmd != D_NONE),
        .i_dividend (dividend),
        .i_divisor  (r_req.base),
        .o_quot     (quot),
        .o_st       (div_st)
    );

    lcdw_sequencer #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_s_axis_tvalid),
        .i_req       (r_req),
        .i_dst       (div_st),
        .i_m_tready  (i_m_axis_tready),
        .o_ready     (o_s_axis_tready),
        .o_div       (div_cmd),
        .o_m_tvalid  (o_m_axis_tvalid),
        .o_m_tdata   (o_m_axis_tdata),
        .o_m_tuser   (o_m_axis_tuser),
        .o_m_tlast   (o_m_axis_tlast)
    );

endmodule
`default_nettype wire

@@ test/char_lcd_text_number_writer_tb.sv @@
`timescale 1ns / 1ps

module char_lcd_text_number_writer_tb;

    import lcdw_pkg::*;

    // One LCD bus write as seen on the output stream
    typedef struct packed {
        logic       is_data;
        logic [7:0] bus_byte;
        logic       last;
    } t_lcd_write;

    // One display request. When n_known is nonzero, the writes are spelled out
    // in known (byte i at [8*i +: 8]) and data_mask (bit i set = data byte).
    // When n_known is zero, the writes come from the model below.
    typedef struct packed {
        t_op         op;
        logic [1:0]  row;
        logic [5:0]  col;
        logic [15:0] value;
        logic [5:0]  base;
        logic [7:0]  ch;
        logic [2:0]  n_known;
        logic [5:0]  data_mask;
        logic [47:0] known;
    } t_lcd_req;

    localparam int N_DIR       = 21;
    localparam int N_PER_PHASE = 165;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_s_axis_tvalid = 1'b0;
    wire         o_s_axis_tready;
    // row[1:0], col[5:0], value[15:0], base[5:0], char_code[7:0], zero pad[1:0]
    logic [39:0] i_s_axis_tdata = '0;
    // op[1:0]
    logic [1:0]  i_s_axis_tuser = OP_INIT;
    wire         o_m_axis_tvalid;
    logic        i_m_axis_tready = 1'b0;
    // bus_byte[7:0]
    wire  [7:0]  o_m_axis_tdata;
    // is_data
    wire         o_m_axis_tuser;
    wire         o_m_axis_tlast;

    // LCD writes predicted for accepted requests, oldest first
    t_lcd_write lcd_writes_due[$];
    t_lcd_req   dir_tab[N_DIR];

    int send_idle_pct = 35;
    int recv_idle_pct = 52;
    int errors = 0;

    char_lcd_text_number_writer uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // Hard stop, well past the slowest legal run: every item a base-2 number
    // of 18 writes with the receiver stalling half the time.
    initial begin
        #10_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Model of the sequencer: queues the writes one request produces.
    function automatic void queue_lcd_writes(input t_lcd_req req);
        logic [7:0]  wr_byte[0:17];
        logic        wr_data[0:17];
        logic [7:0]  cursor;
        logic [15:0] mag;
        int unsigned rest;
        int unsigned radix;
        int unsigned dig[0:15];
        int          nd;
        int          n;
        t_lcd_write  w;
        n = 0;
        nd = 0;
        // cursor: 0x80 | (col - 1), second line adds 0x40, all mod 256
        cursor = {2'b00, req.col} - 8'd1;
        if (req.row != 2'd1)
            cursor = cursor + LCD_LINE2;
        cursor = cursor | LCD_SET_DDRAM;
        case (req.op)
            OP_INIT: begin
                wr_byte[0] = 8'h38; wr_byte[1] = 8'h0C;
                wr_byte[2] = 8'h06; wr_byte[3] = 8'h01;
                for (int i = 0; i < 4; i++)
                    wr_data[i] = 1'b0;
                n = 4;
            end
            OP_CHAR: begin
                wr_byte[0] = cursor;  wr_data[0] = 1'b0;
                wr_byte[1] = req.ch;  wr_data[1] = 1'b1;
                n = 2;
            end
            OP_NUM: begin
                radix = 32'(req.base);
                if (radix < 2)
                    radix = 2;
                if (radix > 36)
                    radix = 36;
                wr_byte[0] = cursor;
                wr_data[0] = 1'b0;
                n = 1;
                // magnitude as unsigned 16 bits so the most negative value works
                mag = req.value[15] ? (16'd0 - req.value) : req.value;
                if (req.value[15]) begin
                    wr_byte[n] = 8'h2D;
                    wr_data[n] = 1'b1;
                    n++;
                end
                rest = 32'(mag);
                do begin
                    dig[nd] = rest % radix;
                    rest = rest / radix;
                    nd++;
                end while (rest != 0);
                while (nd > 0) begin
                    nd--;
                    wr_byte[n] = (dig[nd] < 10) ? 8'(8'h30 + dig[nd])
                                                : 8'(8'h41 + dig[nd] - 10);
                    wr_data[n] = 1'b1;
                    n++;
                end
            end
            default: begin
                n = 0;  // unused op: nothing on the bus
            end
        endcase
        for (int i = 0; i < n; i++) begin
            w.is_data  = wr_data[i];
            w.bus_byte = wr_byte[i];
            w.last     = (i == n - 1);
            lcd_writes_due.push_back(w);
        end
    endfunction

    // Offer one request; the writes it owes are queued on the accepting edge.
    // valid gets exactly one nonblocking write per time step.
    task automatic send_req(input t_lcd_req req);
        t_lcd_write w;
        while ($urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {2'b00, req.ch, req.base, req.value, req.col, req.row};
        i_s_axis_tuser  <= req.op;
        do
            @(posedge i_clk);
        while (!o_s_axis_tready);
        if (req.n_known != 0) begin
            for (int i = 0; i < int'(req.n_known); i++) begin
                w.is_data  = req.data_mask[i];
                w.bus_byte = req.known[8*i +: 8];
                w.last     = (i == int'(req.n_known) - 1);
                lcd_writes_due.push_back(w);
            end
        end else begin
            queue_lcd_writes(req);
        end
    endtask

    // Output side: random backpressure, and each accepted write checked
    // against the oldest one still owed.
    always @(posedge i_clk) begin : bus_side
        t_lcd_write want;
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (lcd_writes_due.size() == 0) begin
                $error("unexpected write: is_data %0d bus_byte %02h last %0d",
                       o_m_axis_tuser, o_m_axis_tdata, o_m_axis_tlast);
                errors++;
            end else begin
                want = lcd_writes_due.pop_front();
                if (o_m_axis_tuser !== want.is_data) begin
                    $error("is_data: expected %0d, got %0d", want.is_data, o_m_axis_tuser);
                    errors++;
                end
                if (o_m_axis_tdata !== want.bus_byte) begin
                    $error("bus_byte: expected %02h, got %02h", want.bus_byte, o_m_axis_tdata);
                    errors++;
                end
                if (o_m_axis_tlast !== want.last) begin
                    $error("last: expected %0d, got %0d", want.last, o_m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    initial begin
        t_lcd_req req;
        int       sel;

        // Directed requests. Columns: op, row, col, value, base, char,
        // known count, data mask, known bytes (first write in the low byte).
        // init sequence
        dir_tab[0]  = '{OP_INIT, 2'd0, 6'd0,  16'h0000, 6'd0,  8'h00,
                        3'd4, 6'b000000, 48'h0000_0106_0C38};
        // top line, first column
        dir_tab[1]  = '{OP_CHAR, 2'd1, 6'd1,  16'h0000, 6'd0,  8'h41,
                        3'd2, 6'b000010, 48'h0000_0000_4180};
        // column zero wraps to 0xFF on the top line
        dir_tab[2]  = '{OP_CHAR, 2'd1, 6'd0,  16'h0000, 6'd0,  8'h00,
                        3'd2, 6'b000010, 48'h0000_0000_00FF};
        // column zero on the second line: 0xFF + 0x40 wraps to 0x3F
        dir_tab[3]  = '{OP_CHAR, 2'd2, 6'd0,  16'hFFFF, 6'd63, 8'hFF,
                        3'd2, 6'b000010, 48'h0000_0000_FFBF};
        // second line, first column
        dir_tab[4]  = '{OP_CHAR, 2'd3, 6'd1,  16'h0000, 6'd0,  8'h2A,
                        3'd2, 6'b000010, 48'h0000_0000_2AC0};
        // zero prints a single '0'
        dir_tab[5]  = '{OP_NUM,  2'd1, 6'd1,  16'h0000, 6'd10, 8'h00,
                        3'd2, 6'b000010, 48'h0000_0000_3080};
        // most negative value in hex: -8000
        dir_tab[6]  = '{OP_NUM,  2'd1, 6'd1,  16'h8000, 6'd16, 8'h00,
                        3'd6, 6'b111110, 48'h3030_3038_2D80};
        // unused op code: nothing comes out
        dir_tab[7]  = '{OP_NONE, 2'd1, 6'd5,  16'h1234, 6'd10, 8'h55,
                        3'd0, 6'b000000, 48'h0};
        // rest go through the model
        dir_tab[8]  = '{OP_CHAR, 2'd0, 6'd63, 16'h0000, 6'd0,  8'h55, 3'd0, 6'd0, 48'h0};
        dir_tab[9]  = '{OP_CHAR, 2'd1, 6'd63, 16'h0000, 6'd0,  8'hAA, 3'd0, 6'd0, 48'h0};
        dir_tab[10] = '{OP_NUM,  2'd1, 6'd2,  16'h7FFF, 6'd2,  8'h00, 3'd0, 6'd0, 48'h0};
        // longest run: cursor, sign, 16 binary digits
        dir_tab[11] = '{OP_NUM,  2'd2, 6'd3,  16'h8000, 6'd2,  8'h00, 3'd0, 6'd0, 48'h0};
        // base 0 and 1 clamp to 2
        dir_tab[12] = '{OP_NUM,  2'd0, 6'd4,  16'hFFFF, 6'd0,  8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[13] = '{OP_NUM,  2'd1, 6'd5,  16'd13,   6'd1,  8'h00, 3'd0, 6'd0, 48'h0};
        // bases above 36 clamp to 36
        dir_tab[14] = '{OP_NUM,  2'd3, 6'd6,  16'd12345, 6'd63, 8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[15] = '{OP_NUM,  2'd1, 6'd7,  16'd1295, 6'd37, 8'h00, 3'd0, 6'd0, 48'h0};
        // top digit 'Z'
        dir_tab[16] = '{OP_NUM,  2'd1, 6'd8,  16'd35,   6'd36, 8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[17] = '{OP_NUM,  2'd2, 6'd40, 16'hCFC7, 6'd10, 8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[18] = '{OP_NUM,  2'd0, 6'd63, 16'h7FFF, 6'd16, 8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[19] = '{OP_NUM,  2'd1, 6'd0,  16'hFFFF, 6'd10, 8'h00, 3'd0, 6'd0, 48'h0};
        dir_tab[20] = '{OP_INIT, 2'd3, 6'd63, 16'hFFFF, 6'd63, 8'hFF, 3'd0, 6'd0, 48'h0};

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int k = 0; k < N_DIR; k++)
            send_req(dir_tab[k]);

        // Random part in three idling phases: receiver-heavy stalls, then
        // sender-heavy gaps, then full throughput on both sides.
        for (int ph = 0; ph < 3; ph++) begin
            case (ph)
                0: begin send_idle_pct = 35; recv_idle_pct = 52; end
                1: begin send_idle_pct = 52; recv_idle_pct = 35; end
                default: begin send_idle_pct = 0; recv_idle_pct = 0; end
            endcase
            for (int j = 0; j < N_PER_PHASE; j++) begin
                sel = $urandom_range(99);
                if (sel < 8)
                    req.op = OP_INIT;
                else if (sel < 38)
                    req.op = OP_CHAR;
                else if (sel < 95)
                    req.op = OP_NUM;
                else
                    req.op = OP_NONE;
                req.row = 2'($urandom_range(3));
                req.col = 6'($urandom_range(63));
                req.ch  = 8'($urandom_range(255));
                // value: extremes, small of both signs, or anything
                case ($urandom_range(7))
                    0: req.value = 16'h8000;
                    1: req.value = 16'h7FFF;
                    2: req.value = 16'($urandom_range(9));
                    3: req.value = 16'd0 - 16'($urandom_range(99));
                    default: req.value = 16'($urandom);
                endcase
                // base: mostly legal, sometimes the usual ones, sometimes clamped
                sel = $urandom_range(9);
                if (sel < 7)
                    req.base = 6'($urandom_range(36, 2));
                else if (sel < 8)
                    req.base = ($urandom_range(1) != 0) ? 6'd10 : 6'd16;
                else
                    req.base = 6'($urandom_range(63));
                req.n_known   = 3'd0;
                req.data_mask = '0;
                req.known     = '0;
                send_req(req);
            end
        end
        i_s_axis_tvalid <= 1'b0;

        // Drain, then keep the clock running so a trailing unused-op request
        // has time to show any stray write.
        while (lcd_writes_due.size() != 0)
            @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (errors == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ sim.f @@
rtl/lcdw_pkg.sv
rtl/lcdw_divider.sv
rtl/lcdw_sequencer.sv
rtl/char_lcd_text_number_writer.sv
test/char_lcd_text_number_writer_tb.sv
